// ===== rtl/core/gta_pkg.sv =====
// Shared types, constants and controller/datapath interface for the track associator.
package gta_pkg;

  localparam int MAX_TRACKS     = 400;
  localparam int DROP_COUNT     = 200;
  localparam int MAX_DETECTIONS = 64;
  localparam int TRK_DEPTH      = MAX_TRACKS + MAX_DETECTIONS;
  localparam int TRK_AW         = $clog2(TRK_DEPTH);
  localparam int TRK_CW         = $clog2(TRK_DEPTH + 1);
  localparam int DET_AW         = $clog2(MAX_DETECTIONS);
  localparam int DET_CW         = $clog2(MAX_DETECTIONS + 1);

  // floor(v/3) == (v * 21846) >> 16 for every 12-bit v
  localparam logic [15:0] THIRD_RECIP = 16'd21846;

  // register reset values
  localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [15:0] RST_DELETE_AGE   = 16'd30;
  localparam logic [15:0] RST_MIN_HITS     = 16'd5;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_ROI_X        = 3'd2,
    REG_ROI_Y        = 3'd3,
    REG_DELETE_AGE   = 3'd4,
    REG_MIN_HITS     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] frame_number;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
  } in_t;

  typedef struct packed {
    logic [31:0] track_id;
    logic        is_new;
    logic [12:0] out_x;
    logic [12:0] out_y;
    logic [11:0] out_w;
    logic [11:0] out_h;
    logic [15:0] hit_count;
    logic        last_of_frame;
  } out_t;

  // settings as seen by the datapath
  typedef struct packed {
    logic [11:0] wx;
    logic [11:0] wy;
    logic [11:0] roi_x;
    logic [11:0] roi_y;
    logic [15:0] delete_age;
    logic [15:0] min_hits;
  } cfg_t;

  typedef struct packed {
    logic [11:0] h;
    logic [11:0] w;
    logic [12:0] y;
    logic [12:0] x;
  } rect_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] last_frame;
    logic [15:0] hits;
    rect_t       rect;
  } trk_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] hits;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic det_wr;
    logic eof_start;
    logic trk_rd;
    logic trk_load;
    logic src_inc;
    logic det_rd;
    logic j_inc;
    logic match_upd;
    logic trk_wb;
    logic new_start;
    logic new_rd;
    logic out_load;
    logic out_next;
    logic frame_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic src_end;
    logic det_end;
    logic taken;
    logic prune;
    logic hit;
  } sts_t;

endpackage

// ===== rtl/core/gta_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gta_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gta_ctrl.sv =====
// Frame-step sequencer: buffering, prune/match pass, new-track and output pass.
module gta_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gta_pkg::sts_t sts,
  output gta_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TRD   = 9'b000000010,
    S_TWT   = 9'b000000100,
    S_DRD   = 9'b000001000,
    S_DCHK  = 9'b000010000,
    S_TWR   = 9'b000100000,
    S_NRD   = 9'b001000000,
    S_NOUT  = 9'b010000000,
    S_OWAIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OWAIT);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type) begin
            cmd.eof_start = 1'b1;
            state_nxt     = S_TRD;
          end else begin
            cmd.det_wr = 1'b1;
          end
        end
      end
      S_TRD: begin
        if (sts.src_end) begin
          cmd.new_start = 1'b1;
          state_nxt     = S_NRD;
        end else begin
          cmd.trk_rd = 1'b1;
          state_nxt  = S_TWT;
        end
      end
      S_TWT: begin
        cmd.trk_load = 1'b1;
        if (sts.prune) begin
          cmd.src_inc = 1'b1;
          state_nxt   = S_TRD;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        if (sts.det_end) begin
          state_nxt = S_TWR;
        end else if (sts.taken) begin
          cmd.j_inc = 1'b1;
        end else begin
          cmd.det_rd = 1'b1;
          state_nxt  = S_DCHK;
        end
      end
      S_DCHK: begin
        if (sts.hit) begin
          cmd.match_upd = 1'b1;
          state_nxt     = S_TWR;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_DRD;
        end
      end
      S_TWR: begin
        cmd.trk_wb = 1'b1;
        state_nxt  = S_TRD;
      end
      S_NRD: begin
        if (sts.det_end) begin
          cmd.frame_done = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.new_rd = 1'b1;
          state_nxt  = S_NOUT;
        end
      end
      S_NOUT: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_ready) begin
          cmd.out_next = 1'b1;
          state_nxt    = S_NRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/gta_dp.sv =====
// Datapath: detection buffer, track table, match logic, result register.
module gta_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  gta_pkg::in_t  in_data,
  input  gta_pkg::cfg_t cfg,
  input  gta_pkg::cmd_t cmd,
  output gta_pkg::sts_t sts,
  output gta_pkg::out_t out_data
);

  logic [gta_pkg::DET_CW-1:0]         det_count_r, j_r;
  logic [gta_pkg::TRK_CW-1:0]         src_r, dst_r, count_r;
  logic [gta_pkg::MAX_DETECTIONS-1:0] taken_r;
  logic [31:0]                        next_id_r, frame_r;
  gta_pkg::trk_t                      trk_r;
  gta_pkg::out_t                      out_r;

  gta_pkg::rect_t det_q, det_new;
  gta_pkg::trk_t  trk_q, trk_new, trk_wdata;
  gta_pkg::res_t  res_q, res_new;
  logic [15:0]    hits_inc;
  logic           det_room, taken_j, trk_we;
  logic [gta_pkg::DET_AW-1:0] j_idx;
  logic [gta_pkg::TRK_AW-1:0] trk_waddr;
  logic [31:0]    age;
  logic [13:0]    dcx, dcy, tcx, tcy, dx, dy;

  assign j_idx    = j_r[gta_pkg::DET_AW-1:0];
  assign taken_j  = taken_r[j_idx];
  assign det_room = det_count_r < gta_pkg::DET_CW'(gta_pkg::MAX_DETECTIONS);

  // detection moved into full-frame coordinates
  always_comb begin
    det_new.x = {1'b0, in_data.rect_x} + {1'b0, cfg.roi_x};
    det_new.y = {1'b0, in_data.rect_y} + {1'b0, cfg.roi_y};
    det_new.w = in_data.rect_w;
    det_new.h = in_data.rect_h;
  end

  gta_ram #(.W($bits(gta_pkg::rect_t)), .D(gta_pkg::MAX_DETECTIONS)) u_det_ram (
    .clk   (clk),
    .we    (cmd.det_wr && det_room),
    .waddr (det_count_r[gta_pkg::DET_AW-1:0]),
    .wdata (det_new),
    .re    (cmd.det_rd || cmd.new_rd),
    .raddr (j_idx),
    .rdata (det_q)
  );

  // saturating hit increment of the loaded track
  assign hits_inc = (trk_r.hits == 16'hFFFF) ? trk_r.hits : trk_r.hits + 16'd1;

  always_comb begin
    res_new.id   = trk_r.id;
    res_new.hits = hits_inc;
  end

  gta_ram #(.W($bits(gta_pkg::res_t)), .D(gta_pkg::MAX_DETECTIONS)) u_res_ram (
    .clk   (clk),
    .we    (cmd.match_upd),
    .waddr (j_idx),
    .wdata (res_new),
    .re    (cmd.new_rd),
    .raddr (j_idx),
    .rdata (res_q)
  );

  // track table: write-back of kept tracks, or append of new ones
  always_comb begin
    trk_new.id         = next_id_r + 32'd1;
    trk_new.last_frame = frame_r;
    trk_new.hits       = 16'd1;
    trk_new.rect       = det_q;
  end

  assign trk_we    = cmd.trk_wb || (cmd.out_load && !taken_j);
  assign trk_waddr = cmd.trk_wb ? dst_r[gta_pkg::TRK_AW-1:0] : count_r[gta_pkg::TRK_AW-1:0];
  assign trk_wdata = cmd.trk_wb ? trk_r : trk_new;

  gta_ram #(.W($bits(gta_pkg::trk_t)), .D(gta_pkg::TRK_DEPTH)) u_trk_ram (
    .clk   (clk),
    .we    (trk_we),
    .waddr (trk_waddr),
    .wdata (trk_wdata),
    .re    (cmd.trk_rd),
    .raddr (src_r[gta_pkg::TRK_AW-1:0]),
    .rdata (trk_q)
  );

  // prune test on the track just read
  assign age = frame_r - trk_q.last_frame;

  // centre distance test, detection against loaded track
  always_comb begin
    dcx = {1'b0, det_q.x} + {3'b0, det_q.w[11:1]};
    dcy = {1'b0, det_q.y} + {3'b0, det_q.h[11:1]};
    tcx = {1'b0, trk_r.rect.x} + {3'b0, trk_r.rect.w[11:1]};
    tcy = {1'b0, trk_r.rect.y} + {3'b0, trk_r.rect.h[11:1]};
    dx  = (dcx > tcx) ? dcx - tcx : tcx - dcx;
    dy  = (dcy > tcy) ? dcy - tcy : tcy - dcy;
  end

  always_comb begin
    sts.src_end = (src_r == count_r);
    sts.det_end = (j_r == det_count_r);
    sts.taken   = taken_j;
    sts.prune   = (age > {16'b0, cfg.delete_age}) && (trk_q.hits < cfg.min_hits);
    sts.hit     = (dx < {2'b0, cfg.wx}) && (dy < {2'b0, cfg.wy});
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_count_r <= '0;
      j_r         <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      count_r     <= '0;
      taken_r     <= '0;
      next_id_r   <= '0;
    end else begin
      if (cmd.det_wr && det_room) begin
        det_count_r <= det_count_r + 1'b1;
      end
      if (cmd.eof_start) begin
        src_r   <= (count_r > gta_pkg::TRK_CW'(gta_pkg::MAX_TRACKS)) ?
                   gta_pkg::TRK_CW'(gta_pkg::DROP_COUNT) : '0;
        dst_r   <= '0;
        taken_r <= '0;
      end
      if (cmd.trk_load || cmd.new_start) begin
        j_r <= '0;
      end
      if (cmd.j_inc || cmd.out_next) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.src_inc) begin
        src_r <= src_r + 1'b1;
      end
      if (cmd.match_upd) begin
        taken_r[j_idx] <= 1'b1;
      end
      if (cmd.trk_wb) begin
        src_r <= src_r + 1'b1;
        dst_r <= dst_r + 1'b1;
      end
      if (cmd.new_start) begin
        count_r <= dst_r;
      end
      if (cmd.out_load && !taken_j) begin
        next_id_r <= next_id_r + 32'd1;
        count_r   <= count_r + 1'b1;
      end
      if (cmd.frame_done) begin
        det_count_r <= '0;
        taken_r     <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.eof_start) begin
      frame_r <= in_data.frame_number;
    end
    if (cmd.trk_load) begin
      trk_r <= trk_q;
    end
    if (cmd.match_upd) begin
      trk_r.hits       <= hits_inc;
      trk_r.last_frame <= frame_r;
      trk_r.rect       <= det_q;
    end
    if (cmd.out_load) begin
      out_r.track_id      <= taken_j ? res_q.id : trk_new.id;
      out_r.is_new        <= !taken_j;
      out_r.out_x         <= det_q.x;
      out_r.out_y         <= det_q.y;
      out_r.out_w         <= det_q.w;
      out_r.out_h         <= det_q.h;
      out_r.hit_count     <= taken_j ? res_q.hits : 16'd1;
      out_r.last_of_frame <= (gta_pkg::DET_CW'(j_r + 1'b1) == det_count_r);
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_det_bound: assert property (@(posedge clk) disable iff (!rst_n)
    det_count_r <= gta_pkg::DET_CW'(gta_pkg::MAX_DETECTIONS))
    else $error("detection count past buffer depth");
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    dst_r <= src_r)
    else $error("compaction write pointer passed read pointer");
  a_trk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gta_pkg::TRK_CW'(gta_pkg::TRK_DEPTH))
    else $error("track count past table depth");
  a_match_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match_upd |-> !taken_j)
    else $error("detection matched twice");
`endif

endmodule

// ===== rtl/core/greedy_track_associator.sv =====
// Top level of the greedy track associator: settings registers and unit wiring.
//
// Requests arrive on in_valid/in_ready. A detection request (req_type 0) is
// buffered; up to 64 are kept per frame, later ones are dropped.
// An end-of-frame request (req_type 1) runs the frame step: old-track drop,
// prune and greedy match in one pass over the track table, then one result
// per buffered detection on out_valid/out_ready, last_of_frame on the final.
// In a track's scan of the detections a match ends the scan, and the
// detection buffer has one read port. in_ready is low for the whole step;
// a stalled receiver holds the result and the step waits.
// Settings are written on cfg_valid/cfg_ready (always ready). They must be
// written only while idle; the block itself does not enforce this.
// Reset (synchronous, rst_n low) empties the track table and the buffer,
// restarts IDs at 1 and loads the default settings; no clearing pass.
module greedy_track_associator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gta_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gta_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  logic [11:0]   frame_width_r, frame_height_r, roi_x_r, roi_y_r;
  logic [15:0]   delete_age_r, min_hits_r;
  logic [11:0]   wx_r, wy_r;
  logic [27:0]   wx_prod, wy_prod;
  gta_pkg::cfg_t cfg;
  gta_pkg::cmd_t cmd;
  gta_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= gta_pkg::RST_FRAME_WIDTH;
      frame_height_r <= gta_pkg::RST_FRAME_HEIGHT;
      roi_x_r        <= '0;
      roi_y_r        <= '0;
      delete_age_r   <= gta_pkg::RST_DELETE_AGE;
      min_hits_r     <= gta_pkg::RST_MIN_HITS;
    end else if (cfg_valid) begin
      case (gta_pkg::cfg_reg_t'(cfg_index))
        gta_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[11:0];
        gta_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[11:0];
        gta_pkg::REG_ROI_X:        roi_x_r        <= cfg_data[11:0];
        gta_pkg::REG_ROI_Y:        roi_y_r        <= cfg_data[11:0];
        gta_pkg::REG_DELETE_AGE:   delete_age_r   <= cfg_data;
        gta_pkg::REG_MIN_HITS:     min_hits_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // match windows: one third of the frame size by reciprocal multiply
  assign wx_prod = {16'b0, frame_width_r} * {12'b0, gta_pkg::THIRD_RECIP};
  assign wy_prod = {16'b0, frame_height_r} * {12'b0, gta_pkg::THIRD_RECIP};

  always_ff @(posedge clk) begin
    wx_r <= wx_prod[27:16];
    wy_r <= wy_prod[27:16];
  end

  always_comb begin
    cfg.wx         = wx_r;
    cfg.wy         = wy_r;
    cfg.roi_x      = roi_x_r;
    cfg.roi_y      = roi_y_r;
    cfg.delete_age = delete_age_r;
    cfg.min_hits   = min_hits_r;
  end

  gta_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  gta_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
